>>> hw/rtl/cdr_pkg.sv
// Shared types and constants for the CPU domain registry.
`default_nettype none
package cdr_pkg;

   localparam int ID_W   = 32;
   localparam int MASK_W = 64;
   localparam int ST_W   = 2;

   localparam int MAX_DOMAINS_DEF = 16;
   localparam int NUM_CPUS_DEF    = 64;

   localparam logic FUNC_UPDATE = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_OVERLAP   = 2'd1;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

   // scan token that walks down the row of slots
   typedef struct packed {
      logic              active;
      logic              overlap;
      logic              found;
      logic              free_seen;
      logic [MASK_W-1:0] old_mask;
   } scan_type;

   // write-back decision broadcast to every slot
   typedef struct packed {
      logic wr_match;
      logic wr_free;
      logic rm_match;
   } commit_type;

endpackage
`default_nettype wire

>>> hw/rtl/cdr_cell.sv
// One table slot: holds an entry, checks the passing scan token and applies write-back.
`default_nettype none
module cdr_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [cdr_pkg::ID_W-1:0]   req_id,
   input  wire logic [cdr_pkg::MASK_W-1:0] req_mask,
   input  wire cdr_pkg::scan_type          tok_in,
   output cdr_pkg::scan_type               tok_out,
   input  wire cdr_pkg::commit_type        commit
);

   logic                      valid_ff;
   logic [cdr_pkg::ID_W-1:0]   id_ff;
   logic [cdr_pkg::MASK_W-1:0] mask_ff;
   logic                      mark_match_ff;
   logic                      mark_free_ff;
   cdr_pkg::scan_type         tok_out_ff;
   cdr_pkg::scan_type         tok_in_nxt;

   logic is_match;
   logic is_free;
   logic is_overlap;
   logic wr_here;

   always_comb begin
      is_match   = valid_ff && (id_ff == req_id);
      is_free    = !valid_ff;
      is_overlap = valid_ff && (id_ff != req_id) && ((mask_ff & req_mask) != '0);

      tok_in_nxt.active    = tok_in.active;
      tok_in_nxt.overlap   = tok_in.overlap | is_overlap;
      tok_in_nxt.found     = tok_in.found | is_match;
      tok_in_nxt.free_seen = tok_in.free_seen | is_free;
      tok_in_nxt.old_mask  = is_match ? mask_ff : tok_in.old_mask;

      wr_here = (commit.wr_match && mark_match_ff) || (commit.wr_free && mark_free_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_out_ff.active <= 1'b0;
      end else begin
         tok_out_ff.active <= tok_in_nxt.active;
      end
      tok_out_ff.overlap   <= tok_in_nxt.overlap;
      tok_out_ff.found     <= tok_in_nxt.found;
      tok_out_ff.free_seen <= tok_in_nxt.free_seen;
      tok_out_ff.old_mask  <= tok_in_nxt.old_mask;
   end

   // marks only move when the request token is here
   always_ff @(posedge clock) begin
      if (reset) begin
         mark_match_ff <= 1'b0;
         mark_free_ff  <= 1'b0;
      end else if (tok_in.active) begin
         mark_match_ff <= is_match;
         mark_free_ff  <= is_free && !tok_in.free_seen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_here) begin
         valid_ff <= 1'b1;
      end else if (commit.rm_match && mark_match_ff) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_here) begin
         id_ff   <= req_id;
         mask_ff <= req_mask;
      end
   end

   assign tok_out = tok_out_ff;

endmodule
`default_nettype wire

>>> hw/rtl/cpu_domain_registry_core.sv
// Top level of the CPU domain registry: request control, slot row and response.
// A request walks the row of MAX_DOMAINS slots one slot per cycle, then commits.
// On its way to the response strobe a request passes launch_ff, each slot's token register and rsp_valid_ff.
// No new request is taken until the previous one has left the slot row; start is ignored while busy.
// The response is shown for one cycle and cannot be stalled; busy drops as it appears.
// Synchronous reset empties the table and leaves the block idle.
`default_nettype none
module cpu_domain_registry_core #(
   parameter int MAX_DOMAINS = cdr_pkg::MAX_DOMAINS_DEF,
   parameter int NUM_CPUS    = cdr_pkg::NUM_CPUS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic                      req_func,
   input  wire logic [cdr_pkg::ID_W-1:0]   req_dom_id,
   input  wire logic [cdr_pkg::MASK_W-1:0] req_cpu_mask,
   output logic                           rsp_valid,
   output logic [cdr_pkg::ST_W-1:0]        rsp_status,
   output logic [cdr_pkg::MASK_W-1:0]      rsp_assign_mask,
   output logic [cdr_pkg::MASK_W-1:0]      rsp_clear_mask
);

   localparam logic [cdr_pkg::MASK_W-1:0] CpuFieldMask =
      {cdr_pkg::MASK_W{1'b1}} >> (cdr_pkg::MASK_W - NUM_CPUS);

   logic                      busy_ff;
   logic                      launch_ff;
   logic                      func_ff;
   logic [cdr_pkg::ID_W-1:0]   id_ff;
   logic [cdr_pkg::MASK_W-1:0] mask_ff;
   logic                      rsp_valid_ff;
   logic [cdr_pkg::ST_W-1:0]   rsp_status_ff;
   logic [cdr_pkg::MASK_W-1:0] rsp_assign_ff;
   logic [cdr_pkg::MASK_W-1:0] rsp_clear_ff;

   logic                      accept;
   logic                      done;
   cdr_pkg::scan_type         tok [MAX_DOMAINS+1];
   cdr_pkg::scan_type         last;
   cdr_pkg::commit_type       commit;
   logic [cdr_pkg::ST_W-1:0]   status_in;
   logic [cdr_pkg::MASK_W-1:0] assign_in;
   logic [cdr_pkg::MASK_W-1:0] clear_in;

   assign accept = start && !busy_ff;
   assign last   = tok[MAX_DOMAINS];
   assign done   = last.active;

   always_comb begin
      tok[0].active    = launch_ff;
      tok[0].overlap   = 1'b0;
      tok[0].found     = 1'b0;
      tok[0].free_seen = 1'b0;
      tok[0].old_mask  = '0;
   end

   for (genvar g = 0; g < MAX_DOMAINS; g++) begin : g_slot
      cdr_cell u_slot (
         .clock    (clock),
         .reset    (reset),
         .req_id   (id_ff),
         .req_mask (mask_ff),
         .tok_in   (tok[g]),
         .tok_out  (tok[g+1]),
         .commit   (commit)
      );
   end

   // decision once the token leaves the last slot
   always_comb begin
      commit    = '0;
      status_in = cdr_pkg::ST_OK;
      assign_in = '0;
      clear_in  = '0;
      if (func_ff == cdr_pkg::FUNC_REMOVE) begin
         if (last.found) begin
            commit.rm_match = done;
            clear_in        = last.old_mask;
         end else begin
            status_in = cdr_pkg::ST_NOT_FOUND;
         end
      end else if (last.overlap) begin
         status_in = cdr_pkg::ST_OVERLAP;
      end else if (last.found) begin
         commit.wr_match = done;
         assign_in       = mask_ff;
         clear_in        = last.old_mask & ~mask_ff;
      end else if (last.free_seen) begin
         commit.wr_free = done;
         assign_in      = mask_ff;
      end else begin
         status_in = cdr_pkg::ST_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         launch_ff    <= accept;
         rsp_valid_ff <= done;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (done) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         id_ff   <= req_dom_id;
         mask_ff <= req_cpu_mask & CpuFieldMask;
      end
      if (done) begin
         rsp_status_ff <= status_in;
         rsp_assign_ff <= assign_in;
         rsp_clear_ff  <= clear_in;
      end
   end

   assign busy            = busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_assign_mask = rsp_assign_ff;
   assign rsp_clear_mask  = rsp_clear_ff;

endmodule
`default_nettype wire
